>>> sv/tvds_pkg.sv
// Shared types and constants for the thermal valve drive sequencer.
// Used by the core, the result buffer and the top level; no dependencies.
`default_nettype none

package tvds_pkg;

   localparam int unsigned DemandWidth = 8;
   localparam int unsigned DriveWidth  = 8;
   localparam int unsigned CsrIdxWidth = 8;
   localparam int unsigned CsrDatWidth = 8;

   localparam logic [DriveWidth-1:0] FULL_DRIVE = 8'd255;
   localparam logic [DriveWidth-1:0] ZERO_DRIVE = 8'd0;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_ON_THRESHOLD      = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_OFF_THRESHOLD     = 8'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PREHEAT_LIMIT     = 8'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_COOLDOWN_INTERVAL = 8'd3;

   typedef struct packed {
      logic [CsrIdxWidth-1:0] index;
      logic [CsrDatWidth-1:0] wdata;
      logic                   write;
   } csr_write_type;

   typedef struct packed {
      logic                  is_idle;
      logic                  is_on;
      logic [DriveWidth-1:0] drive;
   } result_type;

endpackage

`default_nettype wire

>>> sv/thermal_valve_drive_sequencer.sv
// A result is registered in the result buffer and offered from its main register.
// Throughput: one item per cycle unless the result buffer is full; the phase update is
// combinational, and the two-entry buffer keeps input flowing while one result waits.
// Reset (synchronous, active high) returns to the off phase, clears all counts,
// the drive level, the thresholds and intervals, and empties the result buffer.
// Top level: stream ports and configuration port; uses tvds_pkg, tvds_core, tvds_out_buf.
`default_nettype none

module thermal_valve_drive_sequencer
   import tvds_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] demand
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [15:0]                 rsp_tdata,   // [7:0] drive, [8] is_on, [9] is_idle
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [CsrDatWidth-1:0] csr_wdata
);

   csr_write_type csr_wr;
   result_type    result;
   result_type    rsp_item;
   logic          step;
   logic          can_push;

   assign csr_ready    = 1'b1;
   assign csr_wr.write = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.wdata = csr_wdata;

   assign req_tready = can_push;
   assign step       = req_tvalid && can_push;

   tvds_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .step   (step),
      .demand (req_tdata),
      .result (result)
   );

   tvds_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (result),
      .can_push  (can_push),
      .pop_ready (rsp_tready),
      .pop_valid (rsp_tvalid),
      .pop_data  (rsp_item)
   );

   assign rsp_tdata = {6'd0, rsp_item.is_idle, rsp_item.is_on, rsp_item.drive};

endmodule

`default_nettype wire

>>> sv/tvds_core.sv
// Phase sequencer and configuration registers of the valve drive sequencer.
// Depends on tvds_pkg; produces one result per accepted demand item.
`default_nettype none

module tvds_core
   import tvds_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire csr_write_type          csr_wr,
   input  wire logic                   step,
   input  wire logic [DemandWidth-1:0] demand,
   output result_type                  result
);

   typedef enum logic [1:0] {
      PH_OFF     = 2'd0,
      PH_PREHEAT = 2'd1,
      PH_PROP    = 2'd2,
      PH_COOL    = 2'd3
   } phase_type;

   logic [7:0] on_threshold_ff;
   logic [7:0] off_threshold_ff;
   logic [7:0] preheat_limit_ff;
   logic [7:0] cooldown_interval_ff;

   phase_type              phase_ff, phase_in;
   logic [7:0]             preheat_count_ff, preheat_count_in;
   logic [7:0]             second_count_ff, second_count_in;
   logic [DriveWidth-1:0]  drive_level_ff, drive_level_in;

   logic [DemandWidth:0]   demand_plus;
   logic [DriveWidth-1:0]  prop_drive;
   logic [7:0]             second_inc;
   logic                   demand_above_on;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_threshold_ff      <= '0;
         off_threshold_ff     <= '0;
         preheat_limit_ff     <= '0;
         cooldown_interval_ff <= '0;
      end else if (csr_wr.write) begin
         case (csr_wr.index)
            CSR_ON_THRESHOLD:      on_threshold_ff      <= csr_wr.wdata;
            CSR_OFF_THRESHOLD:     off_threshold_ff     <= csr_wr.wdata;
            CSR_PREHEAT_LIMIT:     preheat_limit_ff     <= csr_wr.wdata;
            CSR_COOLDOWN_INTERVAL: cooldown_interval_ff <= csr_wr.wdata;
            default: ;
         endcase
      end
   end

   // Proportional drive is the demand divided by four, rounded up.
   assign demand_plus     = {1'b0, demand} + 9'd3;
   assign prop_drive      = {1'b0, demand_plus[DemandWidth:2]};
   assign second_inc      = second_count_ff + 8'd1;
   assign demand_above_on = demand > on_threshold_ff;

   always_comb begin
      phase_in         = phase_ff;
      preheat_count_in = preheat_count_ff;
      second_count_in  = second_count_ff;
      drive_level_in   = drive_level_ff;
      case (phase_ff)
         PH_OFF: begin
            if (demand_above_on) begin
               phase_in       = PH_PREHEAT;
               drive_level_in = FULL_DRIVE;
            end else begin
               drive_level_in   = ZERO_DRIVE;
               preheat_count_in = '0;
            end
         end
         PH_PREHEAT: begin
            // Leaving preheat keeps the full drive level for this tick.
            if (preheat_limit_ff <= preheat_count_ff) begin
               phase_in = PH_PROP;
            end else begin
               preheat_count_in = preheat_count_ff + 8'd1;
               drive_level_in   = FULL_DRIVE;
            end
         end
         PH_PROP: begin
            if (demand <= off_threshold_ff) begin
               phase_in        = PH_COOL;
               second_count_in = '0;
               drive_level_in  = ZERO_DRIVE;
            end else begin
               drive_level_in = prop_drive;
            end
         end
         PH_COOL: begin
            if (demand_above_on) begin
               phase_in       = PH_PREHEAT;
               drive_level_in = FULL_DRIVE;
            end else if (preheat_count_ff == 8'd0) begin
               phase_in = PH_OFF;
            end else begin
               if (second_inc > cooldown_interval_ff) begin
                  second_count_in  = '0;
                  preheat_count_in = preheat_count_ff - 8'd1;
               end else begin
                  second_count_in = second_inc;
               end
               drive_level_in = ZERO_DRIVE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_OFF;
         preheat_count_ff <= '0;
         second_count_ff  <= '0;
         drive_level_ff   <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         preheat_count_ff <= preheat_count_in;
         second_count_ff  <= second_count_in;
         drive_level_ff   <= drive_level_in;
      end
   end

   assign result.drive   = drive_level_in;
   assign result.is_on   = drive_level_in != ZERO_DRIVE;
   assign result.is_idle = phase_in == PH_OFF;

   a_preheat_full: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PREHEAT |-> drive_level_ff == FULL_DRIVE)
      else $error("preheat phase without full drive");

   a_cool_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COOL |-> drive_level_ff == ZERO_DRIVE)
      else $error("cooldown phase with nonzero drive");

   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_OFF |-> drive_level_ff == ZERO_DRIVE)
      else $error("off phase with nonzero drive");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(preheat_count_ff))
      else $error("state changed without an item");

endmodule

`default_nettype wire

>>> sv/tvds_out_buf.sv
// Two-entry result buffer (main register plus skid register).
// Depends on tvds_pkg; lets the core keep taking items while a result waits.
`default_nettype none

module tvds_out_buf
   import tvds_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            can_push,
   input  wire logic       pop_ready,
   output logic            pop_valid,
   output result_type      pop_data
);

   logic [1:0] count_ff, count_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = count_ff != 2'd0;
   assign can_push  = count_ff != 2'd2;
   assign pop_data  = main_ff;

   always_comb begin
      main_in  = main_ff;
      skid_in  = skid_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (pop && count_ff == 2'd2) begin
         main_in = skid_ff;
      end
      if (push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && pop)) begin
            main_in = push_data;
         end else begin
            skid_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer overfilled");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push)
      else $error("item pushed into full result buffer");

   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      pop_valid && !pop_ready |=> $stable(main_ff))
      else $error("waiting result changed");

endmodule

`default_nettype wire
